// ===== hw/rtl/gb9_pkg.sv =====
// Shared types and constants for the 9x9 Gaussian blur stream.
// Holds the 1-D Q0.24 Gaussian taps, the 2-D coefficient function and the
// pipeline side-band struct. No dependencies.
package gb9_pkg;

  localparam int KERNEL_SIZE = 9;
  localparam int LINES       = KERNEL_SIZE - 1;
  localparam int HALF_K      = KERNEL_SIZE / 2;
  localparam int MAX_HEIGHT  = 2048;
  localparam int CFG_W       = 12;
  localparam int COORD_W     = 11;
  localparam int PIX_W       = 8;
  localparam int TAP_W       = 24;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  // Normalized 1-D Gaussian, sigma 10, unsigned Q0.24
  typedef logic [TAP_W-1:0] tap_arr_t [KERNEL_SIZE];
  localparam tap_arr_t GAUSS_Q24 = '{
    24'd1778383, 24'd1841729, 24'd1888353, 24'd1916892, 24'd1926500,
    24'd1916892, 24'd1888353, 24'd1841729, 24'd1778383
  };

  // 2-D coefficient in Q0.cb, outer product rounded half up.
  // Only ever called with constant arguments.
  function automatic logic [63:0] coef_q(int r, int k, int cb);
    logic [63:0] a;
    logic [63:0] b;
    a = 64'(GAUSS_Q24[r]);
    b = 64'(GAUSS_Q24[k]);
    return (a * b + (64'd1 << (47 - cb))) >> (48 - cb);
  endfunction

  // Side-band data that travels with a pixel down the filter pipe
  typedef struct packed {
    logic               last;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } meta_t;

endpackage

// ===== hw/rtl/gaussian_blur_9x9_stream.sv =====
// Top level of the streaming 9x9 Gaussian blur (sigma 10).
// Instantiates gb9_line_buf and gb9_kernel; depends on gb9_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): one 8-bit pixel per transaction in
//   raster order; frame_start on a transaction restarts at row 0, column 0.
//   Output channel (out_valid / out_stall): one transaction per interior
//   pixel (row and column both in 4 .. size-5) with the blurred value, the
//   centre's row and column, and frame_last on the final interior pixel.
//   Border pixels give no output transaction.
//   Config: cfg_we writes cfg_data to image_width (index 0) or image_height
//   (index 1); only while no transaction is in flight.
//   Throughput: one pixel per clock while the output is not stalled. A result
//   passes five registers: line store read (at the accepting edge), window,
//   products, row sums, total.
//   When the receiver stalls while a result is held, the whole pipe freezes
//   and in_stall follows at once; nothing is dropped.
//   Reset clears the pipe, the position and the sizes (640 x 480). The line
//   store needs no clearing pass: rows are written before they reach a result.
module gaussian_blur_9x9_stream #(
  parameter int MAX_WIDTH = 2048,
  parameter int COEF_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   pixel,
  input  logic                         frame_start,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   filtered,
  output logic [10:0]                  out_row,
  output logic [10:0]                  out_col,
  output logic                         frame_last,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [gb9_pkg::CFG_W-1:0]    cfg_data
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WCMP = (CW + 1 > gb9_pkg::CFG_W) ? CW + 1 : gb9_pkg::CFG_W;
  localparam int OW   = (CW > gb9_pkg::COORD_W) ? CW : gb9_pkg::COORD_W;
  localparam int RW   = gb9_pkg::COORD_W;

  logic [gb9_pkg::CFG_W-1:0] image_width, image_height;
  logic [CW:0]    w_eff;
  logic [RW:0]    h_eff;
  logic [WCMP-1:0] width_x;
  logic [CW-1:0]  col_cnt, col_base;
  logic [RW-1:0]  row_cnt, row_base;
  logic [OW-1:0]  col_ext;
  logic           adv, accept;
  logic           col_wrap, row_wrap, emit_in;
  gb9_pkg::meta_t meta_in, s1_meta, res_meta;
  logic           s1_emit;
  logic           col_valid;
  logic [gb9_pkg::PIX_W*gb9_pkg::KERNEL_SIZE-1:0] column;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= gb9_pkg::CFG_W'(640);
      image_height <= gb9_pkg::CFG_W'(480);
    end else if (cfg_we) begin
      unique case (gb9_pkg::reg_idx_t'(cfg_index))
        gb9_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        gb9_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective sizes: zero acts as one, oversize is clamped
  always_comb begin
    width_x = WCMP'(image_width);
    if (image_width == '0) begin
      w_eff = (CW+1)'(1);
    end else if (width_x > WCMP'(MAX_WIDTH)) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(width_x);
    end
    if (image_height == '0) begin
      h_eff = (RW+1)'(1);
    end else if (image_height > gb9_pkg::CFG_W'(gb9_pkg::MAX_HEIGHT)) begin
      h_eff = (RW+1)'(gb9_pkg::MAX_HEIGHT);
    end else begin
      h_eff = (RW+1)'(image_height);
    end
  end

  // Handshake: the pipe moves unless a held result is stalled
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  // Position of the incoming pixel and what it produces
  always_comb begin
    col_base = frame_start ? '0 : col_cnt;
    row_base = frame_start ? '0 : row_cnt;
    col_wrap = ((CW+1)'(col_base) + (CW+1)'(1)) >= w_eff;
    row_wrap = ((RW+1)'(row_base) + (RW+1)'(1)) >= h_eff;
    emit_in  = (row_base >= RW'(gb9_pkg::LINES)) && (col_base >= CW'(gb9_pkg::LINES));
    col_ext  = OW'(col_base);
    meta_in.last = col_wrap && row_wrap;
    meta_in.row  = row_base - RW'(gb9_pkg::HALF_K);
    meta_in.col  = gb9_pkg::COORD_W'(col_ext - OW'(gb9_pkg::HALF_K));
  end

  // Raster position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col_cnt <= '0;
        row_cnt <= row_wrap ? '0 : row_base + RW'(1);
      end else begin
        col_cnt <= col_base + CW'(1);
        row_cnt <= row_base;
      end
    end
  end

  // Side-band for the pixel in the line-store stage
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_emit <= emit_in;
      s1_meta <= meta_in;
    end
  end

  gb9_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .take      (accept),
    .addr      (col_base),
    .pix       (pixel),
    .col_valid (col_valid),
    .column    (column)
  );

  gb9_kernel #(
    .COEF_BITS (COEF_BITS)
  ) u_kernel (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .shift     (col_valid),
    .emit      (col_valid && s1_emit),
    .meta_in   (s1_meta),
    .column    (column),
    .res_valid (out_valid),
    .res_meta  (res_meta),
    .res_value (filtered)
  );

  assign out_row    = res_meta.row;
  assign out_col    = res_meta.col;
  assign frame_last = res_meta.last;

  // Results only ever come from interior centres
  a_interior: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_row >= 11'd4) && (out_col >= 11'd4))
    else $error("result outside interior");

  // A frame start puts the next position at row 0, column 1
  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    (accept && frame_start && (w_eff > (CW+1)'(1))) |=>
      (col_cnt == CW'(1)) && (row_cnt == '0))
    else $error("frame start did not restart position");

  // Reset empties the pipe and frees the input
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipe not cleared by reset");

endmodule

// ===== hw/rtl/gb9_line_buf.sv =====
// Eight-row line store for the 9x9 blur, one packed word per column.
// Read-modify-write per pixel with a bypass for back-to-back hits on one column.
// Depends on gb9_pkg.
module gb9_line_buf #(
  parameter int MAX_WIDTH = 2048,
  localparam int AW = $clog2(MAX_WIDTH),
  localparam int LINE_W = gb9_pkg::PIX_W * gb9_pkg::LINES,
  localparam int COL_W = gb9_pkg::PIX_W * gb9_pkg::KERNEL_SIZE
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       take,
  input  logic [AW-1:0]              addr,
  input  logic [gb9_pkg::PIX_W-1:0]  pix,
  output logic                       col_valid,
  output logic [COL_W-1:0]           column
);

  logic [LINE_W-1:0] mem [MAX_WIDTH];
  logic [LINE_W-1:0] rd_raw;
  logic [LINE_W-1:0] fwd_word;
  logic              fwd_hit;
  logic [AW-1:0]     s1_addr;
  logic [gb9_pkg::PIX_W-1:0] s1_pix;
  logic [LINE_W-1:0] old_word;
  logic [LINE_W-1:0] wr_word;

  // Oldest row in the low byte; new pixel enters at the top
  always_comb begin
    old_word = fwd_hit ? fwd_word : rd_raw;
    wr_word  = {s1_pix, old_word[LINE_W-1:gb9_pkg::PIX_W]};
    column   = {s1_pix, old_word};
  end

  // Line store: read for the incoming pixel, write back for the staged one
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_raw <= mem[addr];
      if (col_valid) begin
        mem[s1_addr] <= wr_word;
      end
    end
  end

  // Stage valid and bypass flag
  always_ff @(posedge clk) begin
    if (rst) begin
      col_valid <= 1'b0;
      fwd_hit   <= 1'b0;
    end else if (adv) begin
      col_valid <= take;
      fwd_hit   <= col_valid && (s1_addr == addr);
    end
  end

  // Staged payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_addr  <= addr;
      s1_pix   <= pix;
      fwd_word <= wr_word;
    end
  end

endmodule

// ===== hw/rtl/gb9_kernel.sv =====
// 9x9 window and weighted-sum pipeline: products, row sums, total and clamp.
// Holds the output register of the block. Depends on gb9_pkg.
module gb9_kernel #(
  parameter int COEF_BITS = 16,
  localparam int COL_W = gb9_pkg::PIX_W * gb9_pkg::KERNEL_SIZE
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      shift,
  input  logic                      emit,
  input  gb9_pkg::meta_t            meta_in,
  input  logic [COL_W-1:0]          column,
  output logic                      res_valid,
  output gb9_pkg::meta_t            res_meta,
  output logic [gb9_pkg::PIX_W-1:0] res_value
);

  localparam int K  = gb9_pkg::KERNEL_SIZE;
  localparam int PW = COEF_BITS + gb9_pkg::PIX_W;
  localparam int RW = PW + 4;
  localparam int TW = RW + 4;
  localparam int VW = TW - COEF_BITS;

  logic [gb9_pkg::PIX_W-1:0] win [K][K];
  logic [PW-1:0] prod [K][K];
  logic [RW-1:0] rsum_next [K];
  logic [RW-1:0] rsum [K];
  logic [TW-1:0] total;
  logic [VW-1:0] val;
  logic [gb9_pkg::PIX_W-1:0] sat;
  logic s2_valid, s3_valid, s4_valid;
  gb9_pkg::meta_t s2_meta, s3_meta, s4_meta;

  // Window: shift one column left, new column at the right edge
  always_ff @(posedge clk) begin
    if (adv && shift) begin
      for (int r = 0; r < K; r++) begin
        for (int k = 0; k < K - 1; k++) begin
          win[r][k] <= win[r][k+1];
        end
        win[r][K-1] <= column[r*gb9_pkg::PIX_W +: gb9_pkg::PIX_W];
      end
    end
  end

  // One constant-coefficient product per window tap
  for (genvar r = 0; r < K; r++) begin : g_row
    for (genvar k = 0; k < K; k++) begin : g_tap
      localparam logic [COEF_BITS-1:0] C = COEF_BITS'(gb9_pkg::coef_q(r, k, COEF_BITS));
      always_ff @(posedge clk) begin
        if (adv) begin
          prod[r][k] <= PW'(C) * PW'(win[r][k]);
        end
      end
    end
  end

  // Row sums
  always_comb begin
    for (int r = 0; r < K; r++) begin
      rsum_next[r] = '0;
      for (int k = 0; k < K; k++) begin
        rsum_next[r] = rsum_next[r] + RW'(prod[r][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsum <= rsum_next;
    end
  end

  // Total, truncate the fraction, clamp to 8 bits
  always_comb begin
    total = '0;
    for (int r = 0; r < K; r++) begin
      total = total + TW'(rsum[r]);
    end
    val = total[TW-1:COEF_BITS];
    sat = (|val[VW-1:gb9_pkg::PIX_W]) ? '1 : val[gb9_pkg::PIX_W-1:0];
  end

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      s2_valid  <= emit;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      res_valid <= s4_valid;
    end
  end

  // Side-band and result payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_meta   <= meta_in;
      s3_meta   <= s2_meta;
      s4_meta   <= s3_meta;
      res_meta  <= s4_meta;
      res_value <= sat;
    end
  end

endmodule
